### design/i2ct_pkg.sv
// Shared types and constants of the I2C target bus engine.
package i2ct_pkg;

   localparam int ADDR_W = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 7;

   // Address matching and write limits of the target.
   localparam int MAX_ADDRESSES = 4;
   localparam int NUM_ADDR_REGS = 4;
   localparam int WRITE_LIMIT = 32;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_COUNT = 3'd4;

   // Depth of the event queue between the edge classifier and the engine.
   localparam int EVQ_DEPTH = 4;
   localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
   localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

   // Bus events found by the edge classifier.
   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_RISE  = 3'd1;
   localparam logic [2:0] EV_FALL  = 3'd2;
   localparam logic [2:0] EV_START = 3'd3;
   localparam logic [2:0] EV_STOP  = 3'd4;

   typedef struct packed {
      logic [2:0] code;
      logic       sda;
      logic [7:0] read_byte;
      logic       read_byte_present;
   } ev_item_type;

   typedef struct packed {
      logic              sda_drive_low;
      logic              busy_res;
      logic              write_valid;
      logic [7:0]        write_data;
      logic              write_end;
      logic              read_fetch;
      logic              read_end;
      logic [ADDR_W-1:0] matched_address;
   } rsp_item_type;

endpackage

### design/i2ct_front.sv
// Edge classifier: accepts level samples and turns them into bus events.
module i2ct_front
   import i2ct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_scl_level,
   input  logic        req_sda_level,
   input  logic [7:0]  req_read_byte,
   input  logic        req_read_byte_present,
   input  logic        evq_full,
   output logic        ev_push,
   output ev_item_type ev_item
);

   logic seen_ff, seen_in;
   logic last_scl_ff, last_scl_in;
   logic last_sda_ff, last_sda_in;
   logic [2:0] code;

   assign ev_push = req_push && !evq_full;

   always_comb begin
      code = EV_NONE;
      seen_in = seen_ff;
      last_scl_in = last_scl_ff;
      last_sda_in = last_sda_ff;
      if (!seen_ff) begin
         // The first sample only records the levels.
         seen_in = 1'b1;
         last_scl_in = req_scl_level;
         last_sda_in = req_sda_level;
      end else if (req_scl_level != last_scl_ff) begin
         // A clock change wins over a data change in the same sample.
         last_scl_in = req_scl_level;
         last_sda_in = req_sda_level;
         code = req_scl_level ? EV_RISE : EV_FALL;
      end else if (req_sda_level != last_sda_ff) begin
         last_sda_in = req_sda_level;
         if (req_scl_level) begin
            code = req_sda_level ? EV_STOP : EV_START;
         end
      end
   end

   always_comb begin
      ev_item.code = code;
      ev_item.sda = req_sda_level;
      ev_item.read_byte = req_read_byte;
      ev_item.read_byte_present = req_read_byte_present;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         last_scl_ff <= 1'b0;
         last_sda_ff <= 1'b0;
      end else if (ev_push) begin
         seen_ff <= seen_in;
         last_scl_ff <= last_scl_in;
         last_sda_ff <= last_sda_in;
      end
   end

endmodule

### design/i2ct_evq.sv
// Short event queue between the edge classifier and the protocol engine.
module i2ct_evq
   import i2ct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ev_item_type push_item,
   output logic        full,
   input  logic        pop,
   output ev_item_type pop_item,
   output logic        empty
);

   ev_item_type slot_ff [EVQ_DEPTH];
   logic [EVQ_PTR_W-1:0] wr_ff, wr_in;
   logic [EVQ_PTR_W-1:0] rd_ff, rd_in;
   logic [EVQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == EVQ_CNT_W'(EVQ_DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_item = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### design/i2ct_back.sv
// Protocol engine: runs the target state machine on bus events and queues results.
module i2ct_back
   import i2ct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ev_empty,
   input  ev_item_type            ev_item,
   output logic                   ev_pop,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output rsp_item_type           rsp_item
);

   localparam int ADDR_SLOTS =
      (MAX_ADDRESSES < NUM_ADDR_REGS) ? MAX_ADDRESSES : NUM_ADDR_REGS;
   localparam int WCOUNT_W = $clog2(WRITE_LIMIT + 1);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_ADDR  = 3'd1;
   localparam logic [2:0] PH_WRITE = 3'd2;
   localparam logic [2:0] PH_READ  = 3'd3;
   localparam logic [2:0] PH_WAIT  = 3'd4;

   localparam int RQ_DEPTH = 2;

   // Configuration registers.
   logic [ADDR_W-1:0] addr_reg_ff [NUM_ADDR_REGS];
   logic [2:0]        addr_count_ff;

   // Engine state.
   logic [2:0]          phase_ff, phase_in;
   logic [3:0]          pulse_ff, pulse_in;
   logic [7:0]          shift_ff, shift_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                acked_ff, acked_in;
   logic                write_active_ff, write_active_in;
   logic                read_active_ff, read_active_in;
   logic [WCOUNT_W-1:0] wcount_ff, wcount_in;
   logic                pull_ff, pull_in;
   logic [ADDR_W-1:0]   cur_addr_ff, cur_addr_in;

   // Result queue.
   rsp_item_type rq_ff [RQ_DEPTH];
   logic         rq_wr_ff, rq_rd_ff;
   logic [1:0]   rq_cnt_ff;

   logic         take, do_rsp_pop;
   logic         load_req, drive_req, close_req;
   logic         addr_hit;
   logic [ADDR_W-1:0] rx_addr;
   rsp_item_type result;

   assign csr_ready = 1'b1;
   assign take = !ev_empty && (rq_cnt_ff != 2'(RQ_DEPTH));
   assign ev_pop = take;
   assign rsp_empty = (rq_cnt_ff == 2'd0);
   assign do_rsp_pop = rsp_pop && !rsp_empty;
   assign rsp_item = rq_ff[rq_rd_ff];

   assign rx_addr = shift_ff[7:1];

   always_comb begin
      addr_hit = 1'b0;
      for (int k = 0; k < NUM_ADDR_REGS; k++) begin
         if ((k < ADDR_SLOTS) && (int'(addr_count_ff) > k) && (addr_reg_ff[k] == rx_addr)) begin
            addr_hit = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pulse_in = pulse_ff;
      shift_in = shift_ff;
      out_byte_in = out_byte_ff;
      acked_in = acked_ff;
      write_active_in = write_active_ff;
      read_active_in = read_active_ff;
      wcount_in = wcount_ff;
      pull_in = pull_ff;
      cur_addr_in = cur_addr_ff;
      load_req = 1'b0;
      drive_req = 1'b0;
      close_req = 1'b0;
      result = '0;

      case (ev_item.code)
         EV_RISE: begin
            if ((phase_ff == PH_ADDR) || (phase_ff == PH_WRITE)) begin
               if (pulse_ff < 4'd8) begin
                  shift_in = {shift_ff[6:0], ev_item.sda};
               end
               if (pulse_ff != 4'd15) begin
                  pulse_in = pulse_ff + 4'd1;
               end
            end else if (phase_ff == PH_READ) begin
               if (pulse_ff == 4'd8) begin
                  acked_in = !ev_item.sda;
               end
               if (pulse_ff != 4'd15) begin
                  pulse_in = pulse_ff + 4'd1;
               end
            end
         end
         EV_FALL: begin
            if ((phase_ff == PH_IDLE) || (phase_ff == PH_WAIT)) begin
               pull_in = 1'b0;
            end else if (pulse_ff == 4'd0) begin
               // A fall right after START carries no bit.
            end else if (pulse_ff == 4'd8) begin
               if (phase_ff == PH_ADDR) begin
                  if (addr_hit) begin
                     cur_addr_in = rx_addr;
                     pull_in = 1'b1;
                  end else begin
                     phase_in = PH_WAIT;
                     pull_in = 1'b0;
                  end
               end else if (phase_ff == PH_WRITE) begin
                  // Bytes past the limit are still acknowledged but not passed on.
                  if (wcount_ff < WCOUNT_W'(WRITE_LIMIT)) begin
                     result.write_valid = 1'b1;
                     result.write_data = shift_ff;
                     wcount_in = wcount_ff + 1'b1;
                  end
                  pull_in = 1'b1;
               end else begin
                  pull_in = 1'b0;
               end
            end else if (pulse_ff == 4'd9) begin
               pulse_in = 4'd0;
               shift_in = 8'd0;
               if (phase_ff == PH_ADDR) begin
                  if (shift_ff[0]) begin
                     phase_in = PH_READ;
                     read_active_in = 1'b1;
                     load_req = 1'b1;
                     drive_req = 1'b1;
                  end else begin
                     phase_in = PH_WRITE;
                     write_active_in = 1'b1;
                     wcount_in = '0;
                     pull_in = 1'b0;
                  end
               end else if (phase_ff == PH_WRITE) begin
                  pull_in = 1'b0;
               end else if (acked_ff) begin
                  load_req = 1'b1;
                  drive_req = 1'b1;
               end else begin
                  close_req = 1'b1;
                  phase_in = PH_WAIT;
                  pull_in = 1'b0;
               end
            end else if (phase_ff == PH_READ) begin
               drive_req = 1'b1;
            end
         end
         EV_START: begin
            close_req = 1'b1;
            phase_in = PH_ADDR;
            pulse_in = 4'd0;
            shift_in = 8'd0;
            pull_in = 1'b0;
         end
         EV_STOP: begin
            close_req = 1'b1;
            phase_in = PH_IDLE;
            pull_in = 1'b0;
         end
         default: begin
         end
      endcase

      if (close_req) begin
         if (write_active_ff) begin
            write_active_in = 1'b0;
            result.write_end = (wcount_ff != '0);
            wcount_in = '0;
         end
         if (read_active_ff) begin
            read_active_in = 1'b0;
            result.read_end = 1'b1;
         end
      end

      if (load_req) begin
         if (ev_item.read_byte_present) begin
            out_byte_in = ev_item.read_byte;
            result.read_fetch = 1'b1;
         end else begin
            out_byte_in = IDLE_BYTE;
         end
      end

      if (drive_req) begin
         // The bit for the current pulse goes out MSB first; past bit 7 the line is released.
         if (pulse_in < 4'd8) begin
            pull_in = !out_byte_in[3'd7 - pulse_in[2:0]];
         end else begin
            pull_in = 1'b0;
         end
      end

      result.sda_drive_low = pull_in;
      result.busy_res = (phase_in == PH_WRITE) || (phase_in == PH_READ);
      result.matched_address = cur_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ADDR_REGS; k++) begin
            addr_reg_ff[k] <= '0;
         end
         addr_count_ff <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ADDRESS_0: addr_reg_ff[0] <= csr_data;
            CSR_ADDRESS_1: addr_reg_ff[1] <= csr_data;
            CSR_ADDRESS_2: addr_reg_ff[2] <= csr_data;
            CSR_ADDRESS_3: addr_reg_ff[3] <= csr_data;
            CSR_ADDRESS_COUNT: addr_count_ff <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pulse_ff <= '0;
         shift_ff <= '0;
         out_byte_ff <= '0;
         acked_ff <= 1'b0;
         write_active_ff <= 1'b0;
         read_active_ff <= 1'b0;
         wcount_ff <= '0;
         pull_ff <= 1'b0;
         cur_addr_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         pulse_ff <= pulse_in;
         shift_ff <= shift_in;
         out_byte_ff <= out_byte_in;
         acked_ff <= acked_in;
         write_active_ff <= write_active_in;
         read_active_ff <= read_active_in;
         wcount_ff <= wcount_in;
         pull_ff <= pull_in;
         cur_addr_ff <= cur_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rq_ff[rq_wr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff <= 1'b0;
         rq_rd_ff <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         if (take) begin
            rq_wr_ff <= !rq_wr_ff;
         end
         if (do_rsp_pop) begin
            rq_rd_ff <= !rq_rd_ff;
         end
         if (take && !do_rsp_pop) begin
            rq_cnt_ff <= rq_cnt_ff + 2'd1;
         end else if (do_rsp_pop && !take) begin
            rq_cnt_ff <= rq_cnt_ff - 2'd1;
         end
      end
   end

   a_one_phase_active: assert property (@(posedge clock) disable iff (reset)
      !(write_active_ff && read_active_ff))
      else $error("write and read phases active together");

   a_write_phase_open: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WRITE) |-> write_active_ff)
      else $error("write phase without an open write transfer");

   a_read_phase_open: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_READ) |-> read_active_ff)
      else $error("read phase without an open read transfer");

   a_write_count_limit: assert property (@(posedge clock) disable iff (reset)
      wcount_ff <= WCOUNT_W'(WRITE_LIMIT))
      else $error("write count past the limit");

   a_result_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (rq_cnt_ff == 2'(RQ_DEPTH)) |=> (rq_cnt_ff != 2'd3))
      else $error("result queue overflow");

endmodule

### design/i2ct_target_top.sv
// I2C target bus engine top level: edge classifier, event queue and protocol engine.
//
// Usage: push one sample of the SCL and SDA levels per item on the req_ side,
// together with the byte offered for a master read. An item is taken at a clock
// edge with req_push high and req_full low. Every item gives exactly one result
// on the rsp_ side: the SDA pull-down, the busy flag, write and read strobes and
// the matched address. The oldest result is shown while rsp_empty is low and is
// taken at an edge with rsp_pop high.
// The csr_ channel writes the four bus addresses and the address count; it is
// always ready and should be used only while no items are in flight.
// An item is first registered in the event queue; the engine retires it from there
// and writes its result into the result queue, from which the result is shown and
// popped. Throughput: one item per cycle, set by the engine, which retires one bus
// event each cycle while the result queue is not full.
// Reset clears the line history, the protocol state and both queues; addresses
// reset to 0 and the address count to 1. When the result side stalls, the
// two-entry result queue fills, the engine stops, then the four-entry event
// queue fills and req_full rises; no item is lost.
module i2c_target_bus_engine_top
   import i2ct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_scl_level,
   input  logic                   req_sda_level,
   input  logic [7:0]             req_read_byte,
   input  logic                   req_read_byte_present,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_sda_drive_low,
   output logic                   rsp_busy_res,
   output logic                   rsp_write_valid,
   output logic [7:0]             rsp_write_data,
   output logic                   rsp_write_end,
   output logic                   rsp_read_fetch,
   output logic                   rsp_read_end,
   output logic [ADDR_W-1:0]      rsp_matched_address,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic         ev_push, evq_full, ev_pop, ev_empty;
   ev_item_type  ev_in_item, ev_out_item;
   rsp_item_type rsp_item;

   i2ct_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_scl_level         (req_scl_level),
      .req_sda_level         (req_sda_level),
      .req_read_byte         (req_read_byte),
      .req_read_byte_present (req_read_byte_present),
      .evq_full              (evq_full),
      .ev_push               (ev_push),
      .ev_item               (ev_in_item)
   );

   i2ct_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_item (ev_in_item),
      .full      (evq_full),
      .pop       (ev_pop),
      .pop_item  (ev_out_item),
      .empty     (ev_empty)
   );

   i2ct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_empty  (ev_empty),
      .ev_item   (ev_out_item),
      .ev_pop    (ev_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   assign req_full = evq_full;
   assign rsp_sda_drive_low = rsp_item.sda_drive_low;
   assign rsp_busy_res = rsp_item.busy_res;
   assign rsp_write_valid = rsp_item.write_valid;
   assign rsp_write_data = rsp_item.write_data;
   assign rsp_write_end = rsp_item.write_end;
   assign rsp_read_fetch = rsp_item.read_fetch;
   assign rsp_read_end = rsp_item.read_end;
   assign rsp_matched_address = rsp_item.matched_address;

endmodule
